[hw/rtl/tpg_pkg.sv]
package tpg_pkg;

   // fixed field widths
   localparam int COORD_BITS = 16;
   localparam int CSR_W      = 12;
   localparam int NORM_W     = 16;
   localparam int ID_W       = 6;
   localparam int SPAN_W     = COORD_BITS + 1;
   // magnitude of a scaled delta entering the divider
   localparam int DIV_W      = 28;
   // sum of two squared differences, padded to an even width
   localparam int SQ_W       = 2 * SPAN_W;

   localparam logic [ID_W-1:0] NO_ID         = 6'd63;
   localparam logic [1:0]      DISCARD_START = 2'd2;

   // configuration register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ACT_DOWN     = 3'd0,
      ACT_UP       = 3'd1,
      ACT_MOVE     = 3'd2,
      ACT_PTR_DOWN = 3'd3,
      ACT_PTR_UP   = 3'd4,
      ACT_TICK     = 3'd5,
      ACT_OTHER    = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TICK,
      OP_PAN_DOWN,
      OP_PAN_UP,
      OP_PAN_MOVE,
      OP_PINCH_START,
      OP_PINCH_UP,
      OP_PINCH_MOVE
   } op_type;

   typedef logic [COORD_BITS-1:0] coord_type;

   // one classified event between front and back
   typedef struct packed {
      op_type    op;
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      logic [4:0] id0;
      logic [4:0] id1;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DIVA_GO,
      ST_DIVA_WAIT,
      ST_DIVB_GO,
      ST_DIVB_WAIT
   } state_type;

endpackage

[hw/rtl/tpg_front.sv]
module tpg_front import tpg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [2:0] action,
   input  logic [3:0] pointer_count,
   input  coord_type  first_x,
   input  coord_type  first_y,
   input  coord_type  second_x,
   input  coord_type  second_y,
   input  logic [4:0] first_id,
   input  logic [4:0] second_id,
   input  logic       pop,
   output logic       empty,
   output item_type   head
);

   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   item_type   slot_ff [2];
   op_type     op;
   logic       wr_en;
   logic       rd_en;

   // classify the event; ignored ones never enter the queue
   always_comb begin
      op = OP_NONE;
      if (action_type'(action) == ACT_TICK) begin
         op = OP_TICK;
      end else if (pointer_count == 4'd1) begin
         case (action_type'(action))
            ACT_DOWN: op = OP_PAN_DOWN;
            ACT_UP:   op = OP_PAN_UP;
            ACT_MOVE: op = OP_PAN_MOVE;
            default:  op = OP_NONE;
         endcase
      end else if (pointer_count == 4'd2) begin
         case (action_type'(action))
            ACT_PTR_DOWN: op = OP_PINCH_START;
            ACT_PTR_UP:   op = OP_PINCH_UP;
            ACT_MOVE:     op = OP_PINCH_MOVE;
            default:      op = OP_NONE;
         endcase
      end
   end

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign wr_en = push && !full && (op != OP_NONE);
   assign rd_en = pop && !empty;
   assign head  = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      cnt_in    = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue slots
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= '{op: op, ax: first_x, ay: first_y, bx: second_x,
                                 by: second_y, id0: first_id, id1: second_id};
      end
   end

endmodule

[hw/rtl/tpg_div.sv]
module tpg_div import tpg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     neg,
   input  logic [DIV_W-1:0]         num,
   input  logic [CSR_W-1:0]         den,
   output logic                     done,
   output logic signed [NORM_W-1:0] quot
);

   localparam int CNT_W = $clog2(DIV_W);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CSR_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]         q_ff, q_in;
   logic [CSR_W-1:0]         den_ff, den_in;
   logic                     neg_ff, neg_in;
   logic signed [NORM_W-1:0] quot_ff, quot_in;
   logic [CSR_W:0]           rem_sh;
   logic                     ge;
   logic [CSR_W:0]           rem_sub;
   logic [DIV_W-1:0]         q_nx;

   // one restoring step per cycle, quotient shifts in behind the dividend
   assign rem_sh  = {rem_ff, q_ff[DIV_W-1]};
   assign ge      = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign q_nx    = {q_ff[DIV_W-2:0], ge};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
         neg_in  = neg;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[CSR_W-1:0] : rem_sh[CSR_W-1:0];
         q_in   = q_nx;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // truncate toward zero, then saturate to Q5.11 (signed 16 bits)
            if (neg_ff) begin
               if (q_nx >= DIV_W'(32768)) begin
                  quot_in = 16'sh8000;
               end else begin
                  quot_in = -$signed(q_nx[NORM_W-1:0]);
               end
            end else begin
               if (q_nx > DIV_W'(32767)) begin
                  quot_in = 16'sh7fff;
               end else begin
                  quot_in = $signed(q_nx[NORM_W-1:0]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[hw/rtl/tpg_sqrt.sv]
module tpg_sqrt import tpg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   value,
   output logic              done,
   output logic [SPAN_W-1:0] root
);

   localparam int CNT_W = $clog2(SPAN_W);
   localparam int REM_W = SPAN_W + 2;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_W-1:0]   val_ff, val_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SPAN_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;
   logic              ge;
   logic [REM_W+1:0]  rem_sub;

   // one result bit per cycle, two radicand bits brought down each step
   assign rem_sh  = {rem_ff, val_ff[SQ_W-1:SQ_W-2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign ge      = (rem_sh >= trial);
   assign rem_sub = rem_sh - trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in  = {val_ff[SQ_W-3:0], 2'b00};
         rem_in  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_ff[SPAN_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SPAN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hw/rtl/tpg_back.sv]
module tpg_back import tpg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     empty,
   input  item_type                 head,
   output logic                     pop,
   input  logic [CSR_W-1:0]         surface_width,
   input  logic [CSR_W-1:0]         surface_height,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic                     rsp_gesture_active,
   output logic signed [NORM_W-1:0] rsp_move_dx,
   output logic signed [NORM_W-1:0] rsp_move_dy,
   output logic signed [NORM_W-1:0] rsp_span_delta
);

   state_type state_ff, state_in;
   item_type  cur_ff, cur_in;

   logic                     pan_on_ff, pan_on_in;
   logic                     pinch_on_ff, pinch_on_in;
   coord_type                lpan_x_ff, lpan_x_in;
   coord_type                lpan_y_ff, lpan_y_in;
   logic [1:0]               discard_ff, discard_in;
   logic [ID_W-1:0]          id0_ff, id0_in;
   logic [ID_W-1:0]          id1_ff, id1_in;
   coord_type                lpp_ff [4];
   coord_type                lpp_in [4];
   logic [SPAN_W-1:0]        last_span_ff, last_span_in;
   logic signed [NORM_W-1:0] pend_dx_ff, pend_dx_in;
   logic signed [NORM_W-1:0] pend_dy_ff, pend_dy_in;
   logic signed [NORM_W-1:0] pend_fdx_ff, pend_fdx_in;
   logic signed [NORM_W-1:0] pend_sd_ff, pend_sd_in;

   // working registers of one event
   coord_type                pt_ff [4];
   coord_type                pt_in [4];
   logic                     is_move_ff, is_move_in;
   logic                     tgt_pinch_ff, tgt_pinch_in;
   logic [2*COORD_BITS-1:0]  sqx_ff, sqx_in;
   logic [2*COORD_BITS-1:0]  sqy_ff, sqy_in;
   logic [DIV_W-1:0]         ja_num_ff, ja_num_in, jb_num_ff, jb_num_in;
   logic                     ja_neg_ff, ja_neg_in, jb_neg_ff, jb_neg_in;
   logic [CSR_W-1:0]         ja_den_ff, ja_den_in, jb_den_ff, jb_den_in;

   // result register
   logic                     rv_ff, rv_in;
   logic                     ract_ff, ract_in;
   logic signed [NORM_W-1:0] rdx_ff, rdx_in;
   logic signed [NORM_W-1:0] rdy_ff, rdy_in;
   logic signed [NORM_W-1:0] rds_ff, rds_in;

   // shared units
   logic                     div_start, div_done;
   logic [DIV_W-1:0]         div_num;
   logic                     div_neg;
   logic [CSR_W-1:0]         div_den;
   logic signed [NORM_W-1:0] div_quot;
   logic                     sq_start, sq_done;
   logic [SQ_W-1:0]          sq_val;
   logic [SPAN_W-1:0]        sq_root;

   // datapath helpers
   logic [CSR_W-1:0]         wdiv, hdiv, mdiv, maxdim;
   logic signed [COORD_BITS:0] ddx, ddy, sdx, sdy;
   logic [COORD_BITS-1:0]    ddx_mag, ddy_mag, sdx_mag, sdy_mag;
   logic signed [SPAN_W:0]   dspan, dsum;
   logic [SPAN_W-1:0]        dspan_mag, dsum_mag;
   logic                     m_fwd, m_swp;

   tpg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .neg   (div_neg),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   tpg_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_val),
      .done  (sq_done),
      .root  (sq_root)
   );

   // divisors, zero reads as one
   assign wdiv   = (surface_width == '0) ? CSR_W'(1) : surface_width;
   assign hdiv   = (surface_height == '0) ? CSR_W'(1) : surface_height;
   assign maxdim = (surface_width > surface_height) ? surface_width : surface_height;
   assign mdiv   = (maxdim == '0) ? CSR_W'(1) : maxdim;

   // pan displacement
   assign ddx     = $signed({1'b0, cur_ff.ax}) - $signed({1'b0, lpan_x_ff});
   assign ddy     = $signed({1'b0, cur_ff.ay}) - $signed({1'b0, lpan_y_ff});
   assign ddx_mag = ddx[COORD_BITS] ? COORD_BITS'(-ddx) : ddx[COORD_BITS-1:0];
   assign ddy_mag = ddy[COORD_BITS] ? COORD_BITS'(-ddy) : ddy[COORD_BITS-1:0];

   // finger separation
   assign sdx     = $signed({1'b0, pt_ff[2]}) - $signed({1'b0, pt_ff[0]});
   assign sdy     = $signed({1'b0, pt_ff[3]}) - $signed({1'b0, pt_ff[1]});
   assign sdx_mag = sdx[COORD_BITS] ? COORD_BITS'(-sdx) : sdx[COORD_BITS-1:0];
   assign sdy_mag = sdy[COORD_BITS] ? COORD_BITS'(-sdy) : sdy[COORD_BITS-1:0];

   // span change and focus sum change
   assign dspan     = $signed({1'b0, sq_root}) - $signed({1'b0, last_span_ff});
   assign dsum      = $signed({1'b0, {1'b0, pt_ff[0]} + {1'b0, pt_ff[2]}})
                    - $signed({1'b0, {1'b0, lpp_ff[0]} + {1'b0, lpp_ff[2]}});
   assign dspan_mag = dspan[SPAN_W] ? SPAN_W'(-dspan) : dspan[SPAN_W-1:0];
   assign dsum_mag  = dsum[SPAN_W] ? SPAN_W'(-dsum) : dsum[SPAN_W-1:0];

   assign m_fwd = ({1'b0, cur_ff.id0} == id0_ff) && ({1'b0, cur_ff.id1} == id1_ff);
   assign m_swp = ({1'b0, cur_ff.id0} == id1_ff) && ({1'b0, cur_ff.id1} == id0_ff);

   assign div_start = (state_ff == ST_DIVA_GO) || (state_ff == ST_DIVB_GO);
   assign div_num   = (state_ff == ST_DIVB_GO) ? jb_num_ff : ja_num_ff;
   assign div_neg   = (state_ff == ST_DIVB_GO) ? jb_neg_ff : ja_neg_ff;
   assign div_den   = (state_ff == ST_DIVB_GO) ? jb_den_ff : ja_den_ff;
   assign sq_start  = (state_ff == ST_SQRT_GO);
   assign sq_val    = {1'b0, {1'b0, sqx_ff} + {1'b0, sqy_ff}};
   assign pop       = (state_ff == ST_IDLE) && !empty;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pan_on_in    = pan_on_ff;
      pinch_on_in  = pinch_on_ff;
      lpan_x_in    = lpan_x_ff;
      lpan_y_in    = lpan_y_ff;
      discard_in   = discard_ff;
      id0_in       = id0_ff;
      id1_in       = id1_ff;
      lpp_in       = lpp_ff;
      last_span_in = last_span_ff;
      pend_dx_in   = pend_dx_ff;
      pend_dy_in   = pend_dy_ff;
      pend_fdx_in  = pend_fdx_ff;
      pend_sd_in   = pend_sd_ff;
      pt_in        = pt_ff;
      is_move_in   = is_move_ff;
      tgt_pinch_in = tgt_pinch_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      ja_num_in    = ja_num_ff;
      ja_neg_in    = ja_neg_ff;
      ja_den_in    = ja_den_ff;
      jb_num_in    = jb_num_ff;
      jb_neg_in    = jb_neg_ff;
      jb_den_in    = jb_den_ff;
      rv_in        = rv_ff && !rsp_pop;
      ract_in      = ract_ff;
      rdx_in       = rdx_ff;
      rdy_in       = rdy_ff;
      rds_in       = rds_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               cur_in   = head;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_IDLE;
            case (cur_ff.op)
               OP_TICK: begin
                  // wait for the result register to drain
                  if (rv_ff) begin
                     state_in = ST_EXEC;
                  end else begin
                     rv_in   = 1'b1;
                     ract_in = pan_on_ff || pinch_on_ff;
                     rdx_in  = pan_on_ff ? pend_dx_ff : (pinch_on_ff ? pend_fdx_ff : '0);
                     rdy_in  = pan_on_ff ? pend_dy_ff : '0;
                     rds_in  = (!pan_on_ff && pinch_on_ff) ? pend_sd_ff : '0;
                     pend_dx_in  = '0;
                     pend_dy_in  = '0;
                     pend_fdx_in = '0;
                     pend_sd_in  = '0;
                  end
               end
               OP_PAN_DOWN: begin
                  lpan_x_in  = cur_ff.ax;
                  lpan_y_in  = cur_ff.ay;
                  pend_dx_in = '0;
                  pend_dy_in = '0;
                  pan_on_in  = 1'b1;
               end
               OP_PAN_UP: begin
                  lpan_x_in  = '0;
                  lpan_y_in  = '0;
                  pend_dx_in = '0;
                  pend_dy_in = '0;
                  pan_on_in  = 1'b0;
               end
               OP_PAN_MOVE: begin
                  pinch_on_in = 1'b0;
                  lpan_x_in   = cur_ff.ax;
                  lpan_y_in   = cur_ff.ay;
                  if (!pan_on_ff) begin
                     pend_dx_in = '0;
                     pend_dy_in = '0;
                     discard_in = DISCARD_START;
                     pan_on_in  = 1'b1;
                  end else if (discard_ff != 2'd0) begin
                     discard_in = discard_ff - 2'd1;
                  end else begin
                     ja_num_in    = {1'b0, ddx_mag, 11'd0};
                     ja_neg_in    = ddx[COORD_BITS];
                     ja_den_in    = wdiv;
                     jb_num_in    = {1'b0, ddy_mag, 11'd0};
                     jb_neg_in    = ddy[COORD_BITS];
                     jb_den_in    = hdiv;
                     tgt_pinch_in = 1'b0;
                     state_in     = ST_DIVA_GO;
                  end
               end
               OP_PINCH_UP: begin
                  pinch_on_in  = 1'b0;
                  id0_in       = NO_ID;
                  id1_in       = NO_ID;
                  lpp_in       = '{default: '0};
                  last_span_in = '0;
                  pend_fdx_in  = '0;
                  pend_sd_in   = '0;
               end
               OP_PINCH_START, OP_PINCH_MOVE: begin
                  state_in = ST_SQ_X;
                  if ((cur_ff.op == OP_PINCH_MOVE) && (m_fwd || m_swp)) begin
                     is_move_in = 1'b1;
                     if (m_fwd) begin
                        pt_in = '{cur_ff.ax, cur_ff.ay, cur_ff.bx, cur_ff.by};
                     end else begin
                        pt_in = '{cur_ff.bx, cur_ff.by, cur_ff.ax, cur_ff.ay};
                     end
                  end else begin
                     // new pinch, also on unknown ids
                     is_move_in  = 1'b0;
                     pt_in       = '{cur_ff.ax, cur_ff.ay, cur_ff.bx, cur_ff.by};
                     lpp_in      = '{cur_ff.ax, cur_ff.ay, cur_ff.bx, cur_ff.by};
                     pinch_on_in = 1'b1;
                     pan_on_in   = 1'b0;
                     id0_in      = {1'b0, cur_ff.id0};
                     id1_in      = {1'b0, cur_ff.id1};
                     pend_fdx_in = '0;
                     pend_sd_in  = '0;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_SQ_X: begin
            sqx_in   = sdx_mag * sdx_mag;
            state_in = ST_SQ_Y;
         end

         ST_SQ_Y: begin
            sqy_in   = sdy_mag * sdy_mag;
            state_in = ST_SQRT_GO;
         end

         ST_SQRT_GO: begin
            state_in = ST_SQRT_WAIT;
         end

         ST_SQRT_WAIT: begin
            if (sq_done) begin
               last_span_in = sq_root;
               if (!is_move_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ja_num_in    = {dspan_mag, 11'd0};
                  ja_neg_in    = dspan[SPAN_W];
                  ja_den_in    = mdiv;
                  jb_num_in    = {1'b0, dsum_mag, 10'd0};
                  jb_neg_in    = dsum[SPAN_W];
                  jb_den_in    = wdiv;
                  tgt_pinch_in = 1'b1;
                  lpp_in       = pt_ff;
                  state_in     = ST_DIVA_GO;
               end
            end
         end

         ST_DIVA_GO: begin
            state_in = ST_DIVA_WAIT;
         end

         ST_DIVA_WAIT: begin
            if (div_done) begin
               if (tgt_pinch_ff) begin
                  pend_sd_in = div_quot;
               end else begin
                  pend_dx_in = div_quot;
               end
               state_in = ST_DIVB_GO;
            end
         end

         ST_DIVB_GO: begin
            state_in = ST_DIVB_WAIT;
         end

         ST_DIVB_WAIT: begin
            if (div_done) begin
               if (tgt_pinch_ff) begin
                  pend_fdx_in = div_quot;
               end else begin
                  pend_dy_in = div_quot;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and gesture state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rv_ff        <= 1'b0;
         pan_on_ff    <= 1'b0;
         pinch_on_ff  <= 1'b0;
         lpan_x_ff    <= '0;
         lpan_y_ff    <= '0;
         discard_ff   <= '0;
         id0_ff       <= '0;
         id1_ff       <= '0;
         lpp_ff       <= '{default: '0};
         last_span_ff <= '0;
         pend_dx_ff   <= '0;
         pend_dy_ff   <= '0;
         pend_fdx_ff  <= '0;
         pend_sd_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         pan_on_ff    <= pan_on_in;
         pinch_on_ff  <= pinch_on_in;
         lpan_x_ff    <= lpan_x_in;
         lpan_y_ff    <= lpan_y_in;
         discard_ff   <= discard_in;
         id0_ff       <= id0_in;
         id1_ff       <= id1_in;
         lpp_ff       <= lpp_in;
         last_span_ff <= last_span_in;
         pend_dx_ff   <= pend_dx_in;
         pend_dy_ff   <= pend_dy_in;
         pend_fdx_ff  <= pend_fdx_in;
         pend_sd_ff   <= pend_sd_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pt_ff        <= pt_in;
      is_move_ff   <= is_move_in;
      tgt_pinch_ff <= tgt_pinch_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      ja_num_ff    <= ja_num_in;
      ja_neg_ff    <= ja_neg_in;
      ja_den_ff    <= ja_den_in;
      jb_num_ff    <= jb_num_in;
      jb_neg_ff    <= jb_neg_in;
      jb_den_ff    <= jb_den_in;
      ract_ff      <= ract_in;
      rdx_ff       <= rdx_in;
      rdy_ff       <= rdy_in;
      rds_ff       <= rds_in;
   end

   assign rsp_empty          = !rv_ff;
   assign rsp_gesture_active = ract_ff;
   assign rsp_move_dx        = rdx_ff;
   assign rsp_move_dy        = rdy_ff;
   assign rsp_span_delta     = rds_ff;

endmodule

[hw/rtl/touch_pan_pinch_gesture_tracker_core.sv]
// channel   ports                          beat
// -------   -----------------------------  -----------------------------------
// request   push, full, req_*              push && !full, one touch event
// response  empty, pop, rsp_*              pop && !empty, one scene input
// csr       csr_write, csr_index, csr_data write, 0 width, 1 height
//
// Events enter a two-deep queue; ignored events are dropped there.
// Ticks and pan down/up need no arithmetic; a pan move past its discarded
// start runs two serial 28-step divides, a pinch start a 17-step square
// root, a matched pinch move the root plus two divides; one event at a time.
// Synchronous reset clears gesture state; width and height reset to 1.
// A tick waits while the previous scene input has not been popped.
module touch_pan_pinch_gesture_tracker_core import tpg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [2:0]               req_action,
   input  logic [3:0]               req_pointer_count,
   input  logic [15:0]              req_first_x,
   input  logic [15:0]              req_first_y,
   input  logic [15:0]              req_second_x,
   input  logic [15:0]              req_second_y,
   input  logic [4:0]               req_first_id,
   input  logic [4:0]               req_second_id,
   output logic                     empty,
   input  logic                     pop,
   output logic                     rsp_gesture_active,
   output logic signed [NORM_W-1:0] rsp_move_dx,
   output logic signed [NORM_W-1:0] rsp_move_dy,
   output logic signed [NORM_W-1:0] rsp_span_delta,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   logic [CSR_W-1:0] width_ff, width_in;
   logic [CSR_W-1:0] height_ff, height_in;
   logic             q_empty;
   logic             q_pop;
   item_type         q_head;

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_data;
            CSR_HEIGHT: height_in = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_W'(1);
         height_ff <= CSR_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   tpg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .action        (req_action),
      .pointer_count (req_pointer_count),
      .first_x       (req_first_x),
      .first_y       (req_first_y),
      .second_x      (req_second_x),
      .second_y      (req_second_y),
      .first_id      (req_first_id),
      .second_id     (req_second_id),
      .pop           (q_pop),
      .empty         (q_empty),
      .head          (q_head)
   );

   tpg_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (q_empty),
      .head               (q_head),
      .pop                (q_pop),
      .surface_width      (width_ff),
      .surface_height     (height_ff),
      .rsp_empty          (empty),
      .rsp_pop            (pop),
      .rsp_gesture_active (rsp_gesture_active),
      .rsp_move_dx        (rsp_move_dx),
      .rsp_move_dy        (rsp_move_dy),
      .rsp_span_delta     (rsp_span_delta)
   );

endmodule
